// ===== rtl/bcc_pkg.sv =====
package bcc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CfgDebounce = 2'd0;
  localparam logic [1:0] CfgDouble   = 2'd1;
  localparam logic [1:0] CfgLong     = 2'd2;

  // Register reset values.
  localparam logic [15:0] DebounceReset = 16'd50;
  localparam logic [15:0] DoubleReset   = 16'd300;
  localparam logic [15:0] LongReset     = 16'd1000;

  // Timing settings seen by the classifier.
  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] double_click_ms;
    logic [15:0] long_click_ms;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic        stable_level;
    logic        single_event;
    logic        double_event;
    logic        long_event;
    logic [15:0] single_total;
    logic [15:0] double_total;
    logic [15:0] long_total;
  } result_t;

endpackage

// ===== rtl/bcc_cfg_regs.sv =====
module bcc_cfg_regs
  import bcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; an index past the last register is dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDebounce: cfg_d.debounce_ms     = cfg_wdata_i;
        CfgDouble:   cfg_d.double_click_ms = cfg_wdata_i;
        CfgLong:     cfg_d.long_click_ms   = cfg_wdata_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= DebounceReset;
      cfg_q.double_click_ms <= DoubleReset;
      cfg_q.long_click_ms   <= LongReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bcc_classify.sv =====
module bcc_classify
  import bcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        raw_level_i,
  input  logic [31:0] now_ms_i,
  input  cfg_t        cfg_i,
  output result_t     result_o
);

  logic        prev_raw_q, prev_raw_d;
  logic [31:0] deb_stamp_q, deb_stamp_d;
  logic        level_q, level_d;
  logic [31:0] press_stamp_q, press_stamp_d;
  logic        pending_q, pending_d;
  logic [31:0] pend_stamp_q, pend_stamp_d;
  logic        long_rep_q, long_rep_d;
  logic [15:0] single_cnt_q, single_cnt_d;
  logic [15:0] double_cnt_q, double_cnt_d;
  logic [15:0] long_cnt_q, long_cnt_d;

  logic        accept, press, release_acc, long_rel, dbl, start_pend;
  logic        long_rep_a, pending_a, hold_long, sgl, long_inc;
  logic [31:0] el_deb, el_press, el_pend, el_hold, el_pend_a, pend_stamp_a;
  logic [31:0] debounce_ext, double_ext, long_ext;

  assign debounce_ext = {16'd0, cfg_i.debounce_ms};
  assign double_ext   = {16'd0, cfg_i.double_click_ms};
  assign long_ext     = {16'd0, cfg_i.long_click_ms};

  // Debounce: restart the steady timer on every raw change.
  assign deb_stamp_d = (raw_level_i != prev_raw_q) ? now_ms_i : deb_stamp_q;
  assign el_deb      = now_ms_i - deb_stamp_d;
  assign accept      = (el_deb > debounce_ext) && (raw_level_i != level_q);
  assign press       = accept && !raw_level_i;
  assign release_acc = accept && raw_level_i;
  assign level_d     = accept ? raw_level_i : level_q;

  // Release classification against the stamps held before this poll.
  assign el_press   = now_ms_i - press_stamp_q;
  assign el_pend    = now_ms_i - pend_stamp_q;
  assign long_rel   = release_acc && (long_rep_q || (el_press >= long_ext));
  assign dbl        = release_acc && !long_rel && pending_q && (el_pend <= double_ext);
  assign start_pend = release_acc && !long_rel && !dbl;

  assign press_stamp_d = press ? now_ms_i : press_stamp_q;
  assign long_rep_a    = press ? 1'b0 : long_rep_q;
  assign pending_a     = (long_rel || dbl) ? 1'b0 : (start_pend ? 1'b1 : pending_q);
  assign pend_stamp_a  = start_pend ? now_ms_i : pend_stamp_q;

  // Long click while still held, measured from the current press stamp.
  assign el_hold    = now_ms_i - press_stamp_d;
  assign hold_long  = !level_d && !long_rep_a && (el_hold >= long_ext);
  assign long_rep_d = long_rep_a || hold_long;

  // A pending click that outlived its window becomes a single click.
  assign el_pend_a    = now_ms_i - pend_stamp_a;
  assign sgl          = pending_a && (el_pend_a > double_ext);
  assign pending_d    = pending_a && !sgl;
  assign pend_stamp_d = pend_stamp_a;
  assign prev_raw_d   = raw_level_i;

  // A release and a hold cannot both count in one poll.
  assign long_inc     = (long_rel && !long_rep_q) || hold_long;
  assign single_cnt_d = single_cnt_q + {15'd0, sgl};
  assign double_cnt_d = double_cnt_q + {15'd0, dbl};
  assign long_cnt_d   = long_cnt_q + {15'd0, long_inc};

  // State advances once per word that moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q    <= 1'b1;
      deb_stamp_q   <= 32'd0;
      level_q       <= 1'b1;
      press_stamp_q <= 32'd0;
      pending_q     <= 1'b0;
      pend_stamp_q  <= 32'd0;
      long_rep_q    <= 1'b0;
      single_cnt_q  <= 16'd0;
      double_cnt_q  <= 16'd0;
      long_cnt_q    <= 16'd0;
    end else if (step_i) begin
      prev_raw_q    <= prev_raw_d;
      deb_stamp_q   <= deb_stamp_d;
      level_q       <= level_d;
      press_stamp_q <= press_stamp_d;
      pending_q     <= pending_d;
      pend_stamp_q  <= pend_stamp_d;
      long_rep_q    <= long_rep_d;
      single_cnt_q  <= single_cnt_d;
      double_cnt_q  <= double_cnt_d;
      long_cnt_q    <= long_cnt_d;
    end
  end

  assign result_o.stable_level = level_d;
  assign result_o.single_event = sgl;
  assign result_o.double_event = dbl;
  assign result_o.long_event   = long_inc;
  assign result_o.single_total = single_cnt_d;
  assign result_o.double_total = double_cnt_d;
  assign result_o.long_total   = long_cnt_d;

  // A double click never shares a poll with a single or a long click.
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> !(dbl && (sgl || long_inc)))
    else $error("double click counted together with another click");

  // A long click is counted only once while a press is held.
  a_long_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && long_rep_q && !level_q) |-> !hold_long)
    else $error("long click counted twice for one press");

  // The long counter moves only with a long event.
  a_long_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> long_cnt_q == 16'($past(long_cnt_q) + {15'd0, $past(long_inc)}))
    else $error("long counter out of step with long events");

endmodule

// ===== rtl/button_click_classifier_core.sv =====
// Button click classifier. Each input word is one poll of an active-low button
// (raw_level_i, now_ms_i); each poll yields exactly one result word with the
// debounced level, single/double/long click strobes and three wrapping 16-bit
// click totals. A poll passes through an input register, then a result
// register; one poll is accepted every cycle, limited only by the result
// register being taken. Timing registers (index 0 debounce, 1 double-click
// window, 2 long-press time, all in ms) are written through the cfg port,
// which should only be used while no polls are in flight.
module button_click_classifier_core
  import bcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        raw_level_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        stable_level_o,
  output logic        single_event_o,
  output logic        double_event_o,
  output logic        long_event_o,
  output logic [15:0] single_total_o,
  output logic [15:0] double_total_o,
  output logic [15:0] long_total_o
);

  cfg_t        cfg;
  result_t     step_res;
  result_t     res_q;
  logic        s1_valid_q, out_valid_q;
  logic        s1_raw_q;
  logic [31:0] s1_now_q;
  logic        adv, step, s1_load;

  bcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Pipeline control: the result register frees up when empty or taken.
  assign adv        = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && adv;
  assign in_ready_o = !s1_valid_q || adv;
  assign s1_load    = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_raw_q <= raw_level_i;
      s1_now_q <= now_ms_i;
    end
  end

  bcc_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .raw_level_i (s1_raw_q),
    .now_ms_i    (s1_now_q),
    .cfg_i       (cfg),
    .result_o    (step_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign stable_level_o = res_q.stable_level;
  assign single_event_o = res_q.single_event;
  assign double_event_o = res_q.double_event;
  assign long_event_o   = res_q.long_event;
  assign single_total_o = res_q.single_total;
  assign double_total_o = res_q.double_total;
  assign long_total_o   = res_q.long_total;

  // A word waiting in the input register moves on once the result register is empty.
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("poll stuck in input register");

  // No word is dropped: a stalled result keeps the input stage from overwriting it.
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && s1_valid_q) |-> !in_ready_o)
    else $error("input accepted while both stages are full");

  // The totals in a stalled result never change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(res_q))
    else $error("result changed while stalled");

endmodule
